>>> sv/ysc_pkg.sv
package ysc_pkg;

   typedef enum logic [2:0] {
      TAG_STR       = 3'd0,
      TAG_INT       = 3'd1,
      TAG_FLOAT     = 3'd2,
      TAG_BOOL      = 3'd3,
      TAG_NULL      = 3'd4,
      TAG_TIMESTAMP = 3'd5,
      TAG_MERGE     = 3'd6,
      TAG_VALUE     = 3'd7
   } tag_class_type;

   typedef struct packed {
      logic          valid;
      tag_class_type tag_class;
   } result_type;

   localparam int KW_COUNT = 14;

   localparam logic [3:0] TS_YEAR  = 4'd0;
   localparam logic [3:0] TS_MON   = 4'd1;
   localparam logic [3:0] TS_DAY   = 4'd2;
   localparam logic [3:0] TS_TIME  = 4'd3;
   localparam logic [3:0] TS_FRAC0 = 4'd4;
   localparam logic [3:0] TS_FRAC  = 4'd5;
   localparam logic [3:0] TS_SPACE = 4'd6;
   localparam logic [3:0] TS_ZONE  = 4'd7;
   localparam logic [3:0] TS_OFF   = 4'd8;
   localparam logic [3:0] TS_FAIL  = 4'd9;

   typedef struct packed {
      logic [1:0] fi;
      logic [2:0] n;
      logic [3:0] ph;
   } ts_type;

   typedef struct packed {
      logic       fail;
      logic [1:0] d;
      logic       g2;
      logic [1:0] ph;
   } sx_type;

   typedef struct packed {
      logic octd;
      logic oct;
      logic hexd;
      logic hex;
      logic bin;
      logic isx;
      logic isb;
      logic sign;
   } rx_type;

   typedef struct packed {
      logic fail;
      logic esg;
      logic ed;
      logic e;
      logic dot;
      logic dig;
   } dec_type;

   localparam ts_type  TS_RESET  = '{fi: 2'd0, n: 3'd0, ph: TS_YEAR};
   localparam ts_type  TS_FAILED = '{fi: 2'd0, n: 3'd0, ph: TS_FAIL};
   localparam sx_type  SX_RESET  = '{fail: 1'b0, d: 2'd0, g2: 1'b0, ph: 2'd0};
   localparam sx_type  SX_FAILED = '{fail: 1'b1, d: 2'd0, g2: 1'b0, ph: 2'd0};
   localparam rx_type  RX_RESET  = '{octd: 1'b0, oct: 1'b1, hexd: 1'b0, hex: 1'b1,
                                     bin: 1'b1, isx: 1'b0, isb: 1'b0, sign: 1'b0};
   localparam dec_type DEC_RESET = '0;
   localparam dec_type DEC_FAILED = '{fail: 1'b1, default: 1'b0};

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
   endfunction

   function automatic logic [7:0] kw_char(input logic [3:0] b, input logic [2:0] i);
      logic [39:0] w;
      case (b)
         4'd0:    w = {"~", 32'h0};
         4'd1:    w = {"null", 8'h0};
         4'd2:    w = {"yes", 16'h0};
         4'd3:    w = {"true", 8'h0};
         4'd4:    w = {"on", 24'h0};
         4'd5:    w = {"y", 32'h0};
         4'd6:    w = {"no", 24'h0};
         4'd7:    w = "false";
         4'd8:    w = {"off", 16'h0};
         4'd9:    w = {"n", 32'h0};
         4'd10:   w = {"=", 32'h0};
         4'd11:   w = {"<<", 24'h0};
         4'd12:   w = {".inf", 8'h0};
         4'd13:   w = {".nan", 8'h0};
         default: w = '0;
      endcase
      return w[6'd39 - 6'(i) * 6'd8 -: 8];
   endfunction

   function automatic logic [2:0] kw_len(input logic [3:0] b);
      case (b)
         4'd0, 4'd5, 4'd9, 4'd10: return 3'd1;
         4'd4, 4'd6, 4'd11:       return 3'd2;
         4'd2, 4'd8:              return 3'd3;
         4'd7:                    return 3'd5;
         default:                 return 3'd4;
      endcase
   endfunction

   function automatic ts_type ts_zone(input logic [7:0] c);
      ts_type r;
      r = TS_FAILED;
      if (c == " ") r.ph = TS_SPACE;
      else if (c == "Z") r.ph = TS_ZONE;
      else if ((c == "+") || (c == "-")) r.ph = TS_OFF;
      return r;
   endfunction

   function automatic ts_type ts_mk(input logic [3:0] ph, input logic [2:0] n,
                                    input logic [1:0] fi);
      ts_type r;
      r.ph = ph;
      r.n  = n;
      r.fi = fi;
      return r;
   endfunction

   function automatic ts_type ts_step(input ts_type s, input logic [7:0] c);
      logic dg;
      dg = is_dig(c);
      case (s.ph)
         TS_YEAR: begin
            if (dg && (s.n < 3'd4)) return ts_mk(TS_YEAR, s.n + 3'd1, 2'd0);
            if ((c == "-") && (s.n == 3'd4)) return ts_mk(TS_MON, 3'd0, 2'd0);
         end
         TS_MON: begin
            if (dg && (s.n < 3'd2)) return ts_mk(TS_MON, s.n + 3'd1, 2'd0);
            if ((c == "-") && (s.n >= 3'd1)) return ts_mk(TS_DAY, 3'd0, 2'd0);
         end
         TS_DAY: begin
            if (dg && (s.n < 3'd2)) return ts_mk(TS_DAY, s.n + 3'd1, 2'd0);
            if (((c == "T") || (c == "t") || (c == " ")) && (s.n >= 3'd1))
               return ts_mk(TS_TIME, 3'd0, 2'd0);
         end
         TS_TIME: begin
            if (dg) begin
               if (s.n < 3'd2) return ts_mk(TS_TIME, s.n + 3'd1, s.fi);
            end else if (c == ":") begin
               if ((s.n >= 3'd1) && (s.fi < 2'd2)) return ts_mk(TS_TIME, 3'd0, s.fi + 2'd1);
            end else if ((s.fi == 2'd2) && (s.n == 3'd2)) begin
               if (c == ".") return ts_mk(TS_FRAC0, 3'd0, 2'd0);
               return ts_zone(c);
            end
         end
         TS_FRAC0: begin
            if (dg) return ts_mk(TS_FRAC, 3'd0, 2'd0);
         end
         TS_FRAC: begin
            if (dg) return s;
            return ts_zone(c);
         end
         TS_SPACE: return ts_zone(c);
         TS_OFF: begin
            if (dg && (s.n < 3'd4)) return ts_mk(TS_OFF, s.n + 3'd1, 2'd0);
            if ((c == ":") && (s.n == 3'd2)) return s;
         end
         default: ;
      endcase
      return TS_FAILED;
   endfunction

   function automatic logic ts_accept(input ts_type s);
      case (s.ph)
         TS_DAY:                     return s.n >= 3'd1;
         TS_TIME:                    return (s.fi == 2'd2) && (s.n == 3'd2);
         TS_FRAC, TS_SPACE, TS_ZONE: return 1'b1;
         TS_OFF:                     return s.n >= 3'd1;
         default:                    return 1'b0;
      endcase
   endfunction

   function automatic sx_type sx_step(input sx_type s, input logic [7:0] c,
                                      input logic [7:0] prev);
      sx_type r;
      logic   dg;
      dg = is_dig(c);
      r  = SX_RESET;
      if (s.fail) return s;
      case (s.ph)
         2'd0: begin
            if (dg) begin
               r.ph = 2'd1;
               return r;
            end
         end
         2'd1: begin
            if (dg || (c == "_")) return s;
            if (c == ":") begin
               r.ph = 2'd2;
               return r;
            end
         end
         2'd2: begin
            if (dg) begin
               r.ph = 2'd2;
               r.g2 = s.g2;
               if (s.d == 2'd0) begin
                  r.d = 2'd1;
                  return r;
               end
               if ((s.d == 2'd1) && (prev <= "5")) begin
                  r.d = 2'd2;
                  return r;
               end
            end else if ((c == ":") && (s.d >= 2'd1) && !s.g2) begin
               r.ph = 2'd2;
               r.g2 = 1'b1;
               return r;
            end else if ((c == ".") && (s.d >= 2'd1)) begin
               r.ph = 2'd3;
               return r;
            end
         end
         default: begin
            if (dg || (c == "_")) return s;
         end
      endcase
      return SX_FAILED;
   endfunction

   function automatic dec_type dec_step(input dec_type s_in, input logic [7:0] c);
      dec_type s;
      s = s_in;
      if (s.fail) return s;
      if (s.esg) begin
         s.esg = 1'b0;
         if ((c == "+") || (c == "-")) return s;
      end
      if (is_dig(c)) begin
         if (s.e) s.ed = 1'b1;
         else s.dig = 1'b1;
         return s;
      end
      if (((c == "_") || (c == ",")) && !s.e) return s;
      if ((c == ".") && !s.e) begin
         if (s.dot) return DEC_FAILED;
         s.dot = 1'b1;
         return s;
      end
      if (((c == "e") || (c == "E")) && s.dig && !s.e) begin
         s.e   = 1'b1;
         s.esg = 1'b1;
         return s;
      end
      return DEC_FAILED;
   endfunction

   function automatic rx_type rx_step(input rx_type s_in, input logic [3:0] j,
                                      input logic [7:0] c);
      rx_type s;
      s = s_in;
      if (j == 4'd0) begin
         if (c != "0") begin
            s.bin = 1'b0;
            s.hex = 1'b0;
            s.oct = 1'b0;
         end
         return s;
      end
      if ((j == 4'd1) && s.oct) begin
         if ((c == "b") || (c == "B")) s.isb = 1'b1;
         if ((c == "x") || (c == "X")) s.isx = 1'b1;
      end
      if ((c >= "0") && (c <= "7")) s.octd = 1'b1;
      else if (c != "_") s.oct = 1'b0;
      if (j >= 4'd2) begin
         if (!(is_dig(c) || (c == "_")) || ((j == 4'd2) && (c == "_"))) s.bin = 1'b0;
         if (is_hex(c)) s.hexd = 1'b1;
         else if (c != "_") s.hex = 1'b0;
      end
      return s;
   endfunction

endpackage

>>> sv/yaml11_scalar_type_classifier_core.sv
// Classifies a YAML 1.1 plain scalar, sent one byte per transfer with last on the final
// byte, into a tag class code (or null at once for an empty_req transfer). A byte is taken
// every cycle unless stalled; the class appears in the result register the cycle after
// the last byte. The request side stalls only while a result waits under rsp_stall.
module yaml11_scalar_type_classifier_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   input  logic       req_empty_req,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_tag_class
);

   logic                   accept;
   ysc_pkg::result_type    result;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             tag_ff, tag_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   ysc_recog u_recog (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ch        (req_ch),
      .last      (req_last),
      .empty_req (req_empty_req),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tag_in       = tag_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         tag_in       = result.tag_class;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      tag_ff <= tag_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tag_class = tag_ff;

endmodule

>>> sv/ysc_recog.sv
module ysc_recog (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         ch,
   input  logic               last,
   input  logic               empty_req,
   output ysc_pkg::result_type result
);

   localparam int KW_COUNT_W = ysc_pkg::KW_COUNT;

   logic [3:0]                        pos_ff, pos_in;
   logic [ysc_pkg::KW_COUNT-1:0]      kw_ff, kw_in, kw_nx;
   ysc_pkg::ts_type                   ts_ff, ts_in, ts_nx;
   ysc_pkg::sx_type                   sx_ff, sx_in, sx_nx;
   ysc_pkg::rx_type                   rx_ff, rx_in, rx_nx, rx_sg;
   ysc_pkg::dec_type                  dec_ff, dec_in, dec_nx;
   logic [7:0]                        prev_ff, prev_in;
   logic [7:0]                        lc;
   logic                              sign_char;
   logic [3:0]                        rel;
   logic [KW_COUNT_W-1:0]             hit;
   ysc_pkg::tag_class_type            cls;

   always_comb begin
      lc = ((ch >= "A") && (ch <= "Z")) ? ch + 8'd32 : ch;
      sign_char = (pos_ff == 4'd0) && ((ch == "+") || (ch == "-"));
      rx_sg = rx_ff;
      if (sign_char) rx_sg.sign = 1'b1;
      rel = pos_ff - {3'd0, rx_sg.sign};
      kw_nx = kw_ff;
      for (int b = 0; b < KW_COUNT_W; b++) begin
         logic [3:0] idx;
         idx = (b >= 12) ? rel : pos_ff;
         if (!((b >= 12) && sign_char)) begin
            if ((idx >= {1'b0, ysc_pkg::kw_len(4'(b))}) ||
                (ysc_pkg::kw_char(4'(b), idx[2:0]) != lc))
               kw_nx[b] = 1'b0;
         end
      end
      ts_nx  = ts_ff;
      sx_nx  = sx_ff;
      dec_nx = dec_ff;
      rx_nx  = rx_sg;
      if (!sign_char) begin
         ts_nx  = ysc_pkg::ts_step(ts_ff, ch);
         sx_nx  = ysc_pkg::sx_step(sx_ff, ch, prev_ff);
         dec_nx = ysc_pkg::dec_step(dec_ff, ch);
         rx_nx  = ysc_pkg::rx_step(rx_sg, rel, ch);
      end
      for (int b = 0; b < KW_COUNT_W; b++) begin
         logic [3:0] idx;
         idx = (b >= 12) ? rel : pos_ff;
         hit[b] = kw_nx[b] && (({1'b0, idx} + 5'd1) == {2'b0, ysc_pkg::kw_len(4'(b))});
      end
   end

   always_comb begin
      if (hit[0] || hit[1]) cls = ysc_pkg::TAG_NULL;
      else if (|hit[9:2]) cls = ysc_pkg::TAG_BOOL;
      else if (hit[10]) cls = ysc_pkg::TAG_VALUE;
      else if (hit[11]) cls = ysc_pkg::TAG_MERGE;
      else if (rx_nx.sign && (pos_ff == 4'd0)) cls = ysc_pkg::TAG_STR;
      else if (ysc_pkg::ts_accept(ts_nx)) cls = ysc_pkg::TAG_TIMESTAMP;
      else if (hit[12] || hit[13]) cls = ysc_pkg::TAG_FLOAT;
      else if (!sx_nx.fail && (sx_nx.ph == 2'd2) && (sx_nx.d >= 2'd1))
         cls = ysc_pkg::TAG_INT;
      else if (!sx_nx.fail && (sx_nx.ph == 2'd3)) cls = ysc_pkg::TAG_FLOAT;
      else if (rx_nx.isb && (rel >= 4'd2))
         cls = rx_nx.bin ? ysc_pkg::TAG_INT : ysc_pkg::TAG_STR;
      else if (rx_nx.isx && (rel >= 4'd2))
         cls = (rx_nx.hex && rx_nx.hexd) ? ysc_pkg::TAG_INT : ysc_pkg::TAG_STR;
      else if ((rel >= 4'd1) && rx_nx.oct && rx_nx.octd) cls = ysc_pkg::TAG_INT;
      else if (dec_nx.fail) cls = ysc_pkg::TAG_STR;
      else if (dec_nx.dig && (dec_nx.dot || dec_nx.e) && (!dec_nx.e || dec_nx.ed))
         cls = ysc_pkg::TAG_FLOAT;
      else if (dec_nx.dig && !(dec_nx.dot || dec_nx.e)) cls = ysc_pkg::TAG_INT;
      else cls = ysc_pkg::TAG_STR;
   end

   always_comb begin
      pos_in  = pos_ff;
      kw_in   = kw_ff;
      ts_in   = ts_ff;
      sx_in   = sx_ff;
      rx_in   = rx_ff;
      dec_in  = dec_ff;
      prev_in = prev_ff;
      result.valid     = accept && (empty_req || last);
      result.tag_class = empty_req ? ysc_pkg::TAG_NULL : cls;
      if (accept) begin
         if (empty_req || last) begin
            pos_in  = '0;
            kw_in   = '1;
            ts_in   = ysc_pkg::TS_RESET;
            sx_in   = ysc_pkg::SX_RESET;
            rx_in   = ysc_pkg::RX_RESET;
            dec_in  = ysc_pkg::DEC_RESET;
            prev_in = '0;
         end else begin
            pos_in  = (pos_ff == 4'd15) ? pos_ff : pos_ff + 4'd1;
            kw_in   = kw_nx;
            ts_in   = ts_nx;
            sx_in   = sx_nx;
            rx_in   = rx_nx;
            dec_in  = dec_nx;
            prev_in = ch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         kw_ff   <= '1;
         ts_ff   <= ysc_pkg::TS_RESET;
         sx_ff   <= ysc_pkg::SX_RESET;
         rx_ff   <= ysc_pkg::RX_RESET;
         dec_ff  <= ysc_pkg::DEC_RESET;
         prev_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         kw_ff   <= kw_in;
         ts_ff   <= ts_in;
         sx_ff   <= sx_in;
         rx_ff   <= rx_in;
         dec_ff  <= dec_in;
         prev_ff <= prev_in;
      end
   end

endmodule

>>> tb/sv/yaml11_scalar_type_classifier_checker.sv
`timescale 1ns / 100ps

module yaml11_scalar_type_classifier_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   input  logic       req_empty_req,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_tag_class,
   output int         fail_count,
   output int         pending_count
);

   typedef enum logic [3:0] {
      PH_YEAR  = 4'd0,
      PH_MON   = 4'd1,
      PH_DAY   = 4'd2,
      PH_TIME  = 4'd3,
      PH_FRAC0 = 4'd4,
      PH_FRAC  = 4'd5,
      PH_SPACE = 4'd6,
      PH_ZONE  = 4'd7,
      PH_OFF   = 4'd8,
      PH_FAIL  = 4'd9
   } stamp_phase_type;

   typedef struct {
      logic [3:0] ph;
      logic [2:0] n;
      logic [1:0] fi;
   } stamp_type;

   typedef struct {
      bit       fail;
      bit [1:0] ph;
      bit       g2;
      bit [1:0] d;
   } sexa_type;

   typedef struct {
      bit sign, isb, isx, bin, hex, hexd, oct, octd;
   } radix_type;

   typedef struct {
      bit dig, dot, e, ed, esg, fail;
   } decimal_type;

   ysc_pkg::tag_class_type tag_queue[$];

   logic [3:0]  pos_q;
   logic [15:0] word_live;
   stamp_type   stamp_q;
   sexa_type    sexa_q;
   radix_type   radix_q;
   decimal_type dec_q;
   logic [7:0]  prev_ch;
   int          fails = 0;

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic string word_text(int b);
      case (b)
         0: return "~";     1: return "null";  2: return "yes";  3: return "true";
         4: return "on";    5: return "y";     6: return "no";   7: return "false";
         8: return "off";   9: return "n";     10: return "=";   11: return "<<";
         12: return ".inf"; default: return ".nan";
      endcase
   endfunction

   function automatic stamp_type stamp_make(logic [3:0] ph, logic [2:0] n, logic [1:0] fi);
      stamp_type r;
      r.ph = ph;
      r.n  = n;
      r.fi = fi;
      return r;
   endfunction

   function automatic stamp_type stamp_zone(logic [7:0] c);
      if (c == " ") return stamp_make(PH_SPACE, 0, 0);
      if (c == "Z") return stamp_make(PH_ZONE, 0, 0);
      if (c == "+" || c == "-") return stamp_make(PH_OFF, 0, 0);
      return stamp_make(PH_FAIL, 0, 0);
   endfunction

   function automatic stamp_type stamp_next(stamp_type s, logic [7:0] c);
      bit dg;
      dg = digit(c);
      case (s.ph)
         PH_YEAR: begin
            if (dg && s.n < 4) return stamp_make(PH_YEAR, s.n + 1, 0);
            if (c == "-" && s.n == 4) return stamp_make(PH_MON, 0, 0);
         end
         PH_MON: begin
            if (dg && s.n < 2) return stamp_make(PH_MON, s.n + 1, 0);
            if (c == "-" && s.n >= 1) return stamp_make(PH_DAY, 0, 0);
         end
         PH_DAY: begin
            if (dg && s.n < 2) return stamp_make(PH_DAY, s.n + 1, 0);
            if ((c == "T" || c == "t" || c == " ") && s.n >= 1) return stamp_make(PH_TIME, 0, 0);
         end
         PH_TIME: begin
            if (dg) begin
               if (s.n < 2) return stamp_make(PH_TIME, s.n + 1, s.fi);
            end else if (c == ":") begin
               if (s.n >= 1 && s.fi < 2) return stamp_make(PH_TIME, 0, s.fi + 1);
            end else if (s.fi == 2 && s.n == 2) begin
               if (c == ".") return stamp_make(PH_FRAC0, 0, 0);
               return stamp_zone(c);
            end
         end
         PH_FRAC0: if (dg) return stamp_make(PH_FRAC, 0, 0);
         PH_FRAC: begin
            if (dg) return s;
            return stamp_zone(c);
         end
         PH_SPACE: return stamp_zone(c);
         PH_OFF: begin
            if (dg && s.n < 4) return stamp_make(PH_OFF, s.n + 1, 0);
            if (c == ":" && s.n == 2) return s;
         end
         default: ;
      endcase
      return stamp_make(PH_FAIL, 0, 0);
   endfunction

   function automatic bit stamp_done(stamp_type s);
      case (s.ph)
         PH_DAY: return s.n >= 1;
         PH_TIME: return s.fi == 2 && s.n == 2;
         PH_FRAC, PH_SPACE, PH_ZONE: return 1;
         PH_OFF: return s.n >= 1;
         default: return 0;
      endcase
   endfunction

   function automatic sexa_type sexa_next(sexa_type s, logic [7:0] c, logic [7:0] prev);
      sexa_type r;
      bit dg;
      dg = digit(c);
      r = '{default: 0};
      if (s.fail) return s;
      case (s.ph)
         0: if (dg) begin
            r.ph = 1;
            return r;
         end
         1: begin
            if (dg || c == "_") return s;
            if (c == ":") begin
               r.ph = 2;
               return r;
            end
         end
         2: begin
            r.ph = 2;
            if (dg) begin
               r.g2 = s.g2;
               if (s.d == 0) begin
                  r.d = 1;
                  return r;
               end
               if (s.d == 1 && prev <= "5") begin
                  r.d = 2;
                  return r;
               end
            end else if (c == ":" && s.d >= 1 && !s.g2) begin
               r.g2 = 1;
               return r;
            end else if (c == "." && s.d >= 1) begin
               r.ph = 3;
               return r;
            end
         end
         default: if (dg || c == "_") return s;
      endcase
      r = '{default: 0};
      r.fail = 1;
      return r;
   endfunction

   function automatic decimal_type dec_next(decimal_type s, logic [7:0] c);
      decimal_type f;
      f = '{default: 0};
      f.fail = 1;
      if (s.fail) return s;
      if (s.esg) begin
         s.esg = 0;
         if (c == "+" || c == "-") return s;
      end
      if (digit(c)) begin
         if (s.e) s.ed = 1;
         else s.dig = 1;
         return s;
      end
      if ((c == "_" || c == ",") && !s.e) return s;
      if (c == "." && !s.e) begin
         if (s.dot) return f;
         s.dot = 1;
         return s;
      end
      if ((c == "e" || c == "E") && s.dig && !s.e) begin
         s.e = 1;
         s.esg = 1;
         return s;
      end
      return f;
   endfunction

   function automatic radix_type radix_next(radix_type s, logic [3:0] j, logic [7:0] c);
      bit hx;
      hx = digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      if (j == 0) begin
         if (c != "0") begin
            s.bin = 0;
            s.hex = 0;
            s.oct = 0;
         end
         return s;
      end
      if (j == 1 && s.oct) begin
         if (c == "b" || c == "B") s.isb = 1;
         if (c == "x" || c == "X") s.isx = 1;
      end
      if (c >= "0" && c <= "7") s.octd = 1;
      else if (c != "_") s.oct = 0;
      if (j >= 2) begin
         if (!(digit(c) || c == "_") || (j == 2 && c == "_")) s.bin = 0;
         if (hx) s.hexd = 1;
         else if (c != "_") s.hex = 0;
      end
      return s;
   endfunction

   function automatic bit word_hit(logic [15:0] live, int b, int idx);
      string w;
      w = word_text(b);
      return live[b] && idx + 1 == w.len();
   endfunction

   function automatic ysc_pkg::tag_class_type scalar_class(int pos, logic [15:0] live,
                                                           stamp_type st, sexa_type sx,
                                                           radix_type rx, decimal_type dc);
      int rel;
      if (word_hit(live, 0, pos) || word_hit(live, 1, pos)) return ysc_pkg::TAG_NULL;
      for (int b = 2; b < 10; b++)
         if (word_hit(live, b, pos)) return ysc_pkg::TAG_BOOL;
      if (word_hit(live, 10, pos)) return ysc_pkg::TAG_VALUE;
      if (word_hit(live, 11, pos)) return ysc_pkg::TAG_MERGE;
      if (rx.sign && pos == 0) return ysc_pkg::TAG_STR;
      rel = pos - int'(rx.sign);
      if (stamp_done(st)) return ysc_pkg::TAG_TIMESTAMP;
      if (word_hit(live, 12, rel) || word_hit(live, 13, rel)) return ysc_pkg::TAG_FLOAT;
      if (!sx.fail) begin
         if (sx.ph == 2 && sx.d >= 1) return ysc_pkg::TAG_INT;
         if (sx.ph == 3) return ysc_pkg::TAG_FLOAT;
      end
      if (rx.isb && rel >= 2) return rx.bin ? ysc_pkg::TAG_INT : ysc_pkg::TAG_STR;
      if (rx.isx && rel >= 2)
         return (rx.hex && rx.hexd) ? ysc_pkg::TAG_INT : ysc_pkg::TAG_STR;
      if (rel >= 1 && rx.oct && rx.octd) return ysc_pkg::TAG_INT;
      if (dc.fail) return ysc_pkg::TAG_STR;
      if (dc.dig && (dc.dot || dc.e) && (!dc.e || dc.ed)) return ysc_pkg::TAG_FLOAT;
      if (dc.dig && !(dc.dot || dc.e)) return ysc_pkg::TAG_INT;
      return ysc_pkg::TAG_STR;
   endfunction

   task automatic clear_scalar();
      pos_q     = 0;
      word_live = 16'hFFFF;
      stamp_q   = stamp_make(PH_YEAR, 0, 0);
      sexa_q    = '{default: 0};
      radix_q   = '{default: 0};
      radix_q.bin = 1;
      radix_q.hex = 1;
      radix_q.oct = 1;
      dec_q     = '{default: 0};
      prev_ch   = 0;
   endtask

   task automatic take_byte(logic [7:0] c, logic last, logic empty);
      logic [7:0] lc;
      bit         sign_char;
      int         rel, idx;
      string      w;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      if (empty) begin
         clear_scalar();
         tag_queue.push_back(ysc_pkg::TAG_NULL);
         return;
      end
      sign_char = pos_q == 0 && (c == "+" || c == "-");
      if (sign_char) radix_q.sign = 1;
      rel = int'(pos_q) - int'(radix_q.sign);
      for (int b = 0; b < 14; b++) begin
         if (b >= 12 && sign_char) continue;
         idx = b >= 12 ? rel : int'(pos_q);
         w = word_text(b);
         if (idx >= w.len() || w[idx] != lc) word_live[b] = 0;
      end
      if (!sign_char) begin
         stamp_q = stamp_next(stamp_q, c);
         sexa_q  = sexa_next(sexa_q, c, prev_ch);
         dec_q   = dec_next(dec_q, c);
         radix_q = radix_next(radix_q, 4'(rel), c);
      end
      prev_ch = c;
      if (last) begin
         tag_queue.push_back(scalar_class(pos_q, word_live, stamp_q, sexa_q, radix_q, dec_q));
         clear_scalar();
      end else if (pos_q < 15) begin
         pos_q++;
      end
   endtask

   assign pending_count = tag_queue.size();
   assign fail_count    = fails;

   always @(posedge clock) begin
      ysc_pkg::tag_class_type want;
      if (reset) begin
         clear_scalar();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tag_queue.size() == 0) begin
               $error("tag_class: unexpected transfer, actual %0d", rsp_tag_class);
               fails++;
            end else begin
               want = tag_queue.pop_front();
               if (rsp_tag_class !== want) begin
                  $error("tag_class: expected %0d, actual %0d", want, rsp_tag_class);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) take_byte(req_ch, req_last, req_empty_req);
      end
   end

   final if (tag_queue.size() != 0)
      $error("tag_class: %0d expected transfers never arrived", tag_queue.size());

endmodule

>>> tb/sv/yaml11_scalar_type_classifier_core_tb.sv
`timescale 1ns / 100ps

module yaml11_scalar_type_classifier_core_tb;

   localparam int IDLE_LIMIT = 2000;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   logic [7:0] req_ch = 0;
   logic       req_last = 0;
   logic       req_empty_req = 0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   logic [2:0] rsp_tag_class;
   int         fail_count;
   int         pending_count;
   int         idle_cycles = 0;
   int         burst_left = 0;
   string      scalars[$];

   always #5 clock = ~clock;

   yaml11_scalar_type_classifier_core dut (.*);

   yaml11_scalar_type_classifier_checker checker_inst (.*);

   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else case ($urandom_range(0, 9))
         0, 1, 2: rsp_stall <= 1;
         default: rsp_stall <= ($urandom_range(0, 63) < 4);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] c, logic last, logic empty);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid     <= 1;
      req_ch        <= c;
      req_last      <= last;
      req_empty_req <= empty;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_scalar(string s);
      if (s.len() == 0) send_byte(8'($urandom), 1'($urandom), 1);
      else for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1, 0);
   endtask

   function automatic string rand_digits(int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
      return s;
   endfunction

   function automatic string mutate(string s);
      int k;
      k = $urandom_range(0, s.len() - 1);
      case ($urandom_range(0, 2))
         0: s[k] = 8'($urandom);
         1: s[k] = "_";
         default: s = s.substr(0, k);
      endcase
      return s;
   endfunction

   function automatic string rand_scalar();
      string pool[] = '{"~", "Null", "YES", "tRuE", "on", "Y", "no", "False", "OFF", "n",
                        "=", "<<", "+.inf", "-.NaN", ".inf", "0b1019", "0B_1", "0x_fF",
                        "0x", "0o17", "017", "0_7", "1_000,5", "1.5e+3", "-2E5", "1e",
                        "190:20:30.15", "1:59", "1:60", "+12", "-", "+"};
      string s;
      case ($urandom_range(0, 9))
         0: s = pool[$urandom_range(0, pool.size() - 1)];
         1: s = {rand_digits(4), "-", rand_digits($urandom_range(1, 2)), "-",
                 rand_digits($urandom_range(1, 2))};
         2: s = {rand_digits(4), "-0", rand_digits(1), "-1", rand_digits(1), "T",
                 rand_digits(2), ":", rand_digits(2), ":", rand_digits(2),
                 ($urandom_range(0, 1) ? {".", rand_digits(2)} : ""),
                 ($urandom_range(0, 1) ? "Z" : {" -0", rand_digits(1), ":00"})};
         3: s = {($urandom_range(0, 1) ? "-" : ""), rand_digits($urandom_range(1, 3)), ":",
                 rand_digits(2), ($urandom_range(0, 1) ? ".5" : "")};
         4: s = {"0x", rand_digits($urandom_range(1, 3)), "aF"};
         5: s = {($urandom_range(0, 1) ? "+" : ""), rand_digits($urandom_range(1, 5)),
                 ($urandom_range(0, 1) ? {".", rand_digits(2)} : ""),
                 ($urandom_range(0, 1) ? {"e-", rand_digits(1)} : "")};
         6: s = {"0", rand_digits($urandom_range(1, 4))};
         7: begin
            s = "";
            repeat ($urandom_range(1, 20)) s = {s, string'(8'($urandom))};
         end
         8: s = mutate(pool[$urandom_range(0, pool.size() - 1)]);
         default: s = mutate({rand_digits(4), "-12-31 10:00:00"});
      endcase
      return s;
   endfunction

   initial begin
      scalars = '{"", "~", "NULL", "yEs", "TRUE", "On", "y", "N", "no", "fAlSe", "off",
                  "=", "<<", "+.inf", "-.NAN", ".inf", "+", "-", "0b102", "0b_1",
                  "0xDeadBeef", "0x_", "0777", "089", "1_000.5e+10", "2001-12-14t21:59:43.10-05:00",
                  "190:20:30", "3.", "abcdefghijklmnopqrst"};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (scalars[i]) send_scalar(scalars[i]);
      send_byte(8'hFF, 0, 0);
      send_byte(8'h00, 0, 1);
      for (int i = 0; i < 40; i++) begin
         if (i == 20) begin
            req_valid <= 0;
            burst_left = 0;
            do @(posedge clock); while (pending_count != 0);
         end
         send_scalar(rand_scalar());
      end
      req_valid <= 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
